>>> rtl/core/cvsb_pkg.sv
// Package: constants, tables and arithmetic helpers for the SVF vocoder bank.
package cvsb_pkg;

  localparam int unsigned DefaultBands = 10;
  localparam int unsigned TableLen = 10;

  localparam logic [15:0] EnvDecayReset = 16'd64667;
  localparam logic [15:0] DampFirstReset = 16'd9509;
  localparam logic [15:0] DampSecondReset = 16'd9593;

  localparam logic [1:0] RegEnvDecay = 2'd0;
  localparam logic [1:0] RegDampFirst = 2'd1;
  localparam logic [1:0] RegDampSecond = 2'd2;

  // first-stage tuning, Q1.16
  function automatic logic [17:0] cut_first(input int unsigned idx);
    logic [17:0] v;
    case (idx)
      0: v = 18'd1955;
      1: v = 18'd2807;
      2: v = 18'd4055;
      3: v = 18'd6081;
      4: v = 18'd9117;
      5: v = 18'd13330;
      6: v = 18'd19481;
      7: v = 18'd27862;
      8: v = 18'd39911;
      default: v = 18'd58671;
    endcase
    return v;
  endfunction

  // second-stage tuning, Q1.16
  function automatic logic [17:0] cut_second(input int unsigned idx);
    logic [17:0] v;
    case (idx)
      0: v = 18'd2369;
      1: v = 18'd3401;
      2: v = 18'd4912;
      3: v = 18'd7366;
      4: v = 18'd11041;
      5: v = 18'd16136;
      6: v = 18'd23559;
      7: v = 18'd33633;
      8: v = 18'd47987;
      default: v = 18'd69873;
    endcase
    return v;
  endfunction

  // per-band mix gain, Q1.16
  function automatic logic [16:0] mix_level(input int unsigned idx);
    logic [16:0] v;
    case (idx)
      0, 1, 2, 3: v = 17'd65536;
      4: v = 17'd53971;
      5: v = 17'd44756;
      default: v = 17'd36700;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // round-half-up product shift of a Q8.24 value by a Q.16 coefficient
  function automatic logic signed [34:0] rnd16(input logic signed [50:0] p);
    logic signed [50:0] t;
    t = p + 51'sd32768;
    return t[50:16];
  endfunction

endpackage

>>> rtl/core/channel_vocoder_svf_bank_unit.sv
// Ten-band channel vocoder: SVF bandpass pairs, envelope followers, weighted mix.
// Each band takes four SVF stages of seven steps plus three envelope/mix steps.
// A new word is taken only after the previous result has been taken, so out_stall
// also holds back the input.
// Reset clears all filter and envelope state by a sweep over all 4*BANDS entries
// before the first word is taken; registers return to their defaults at once.
module channel_vocoder_svf_bank_unit #(
  parameter int unsigned BANDS = cvsb_pkg::DefaultBands
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] carrier_sample,
  input  logic signed [15:0] modulator_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] output_sample
);

  localparam int unsigned Entries = 4 * BANDS;
  localparam int unsigned AW = $clog2(Entries);
  localparam int unsigned BW = $clog2(BANDS + 1);
  localparam int unsigned EW = $clog2(BANDS) > 0 ? $clog2(BANDS) : 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RUN   = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  // per-stage micro steps
  typedef enum logic [2:0] {
    P_READ = 3'd0, P_WAIT = 3'd1, P_LO = 3'd2, P_HI1 = 3'd3,
    P_HI2 = 3'd4, P_BP = 3'd5, P_WR = 3'd6
  } phase_t;

  state_t state;
  logic [15:0] env_decay, damp1, damp2;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      env_decay <= cvsb_pkg::EnvDecayReset;
      damp1 <= cvsb_pkg::DampFirstReset;
      damp2 <= cvsb_pkg::DampSecondReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cvsb_pkg::RegEnvDecay: env_decay <= cfg_data;
        cvsb_pkg::RegDampFirst: damp1 <= cfg_data;
        cvsb_pkg::RegDampSecond: damp2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // state memories: lowpass and bandpass share an address, envelopes separate
  logic signed [31:0] lp_mem [Entries];
  logic signed [31:0] bp_mem [Entries];
  logic signed [31:0] env_mem [BANDS];
  logic [AW-1:0] mem_addr;
  logic mem_we;
  logic signed [31:0] lp_wdata, bp_wdata, lp_rd, bp_rd;
  logic [EW-1:0] env_addr;
  logic env_we;
  logic signed [31:0] env_wdata, env_rd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lp_mem[mem_addr[AW-1:0]] <= lp_wdata;
      bp_mem[mem_addr[AW-1:0]] <= bp_wdata;
    end
    lp_rd <= lp_mem[mem_addr[AW-1:0]];
    bp_rd <= bp_mem[mem_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (env_we) env_mem[env_addr] <= env_wdata;
    env_rd <= env_mem[env_addr];
  end

  // sequencer
  logic [AW-1:0] clr_cnt;
  logic [BW-1:0] band;
  logic [1:0] stage;     // 0 car1, 1 car2, 2 mod1, 3 mod2
  logic [2:0] phase;     // step within a stage
  logic [1:0] tail;      // envelope/mix steps after the four stages
  logic signed [31:0] car_x, mod_x;
  logic signed [31:0] lo, hi, b, stg_in;
  logic signed [31:0] car_bp2, mod_bp1, car_band;
  logic signed [32:0] mag;   // |INT32_MIN| needs the extra bit
  logic signed [35:0] tmp;
  logic signed [63:0] acc;
  logic signed [50:0] prod;
  logic signed [32:0] mula;
  logic [17:0] mulc;
  logic [17:0] f_coef, q_coef;
  logic signed [15:0] res;
  logic [16:0] mix_g;
  logic signed [39:0] mix_term;   // (env * bp) >>> 24 of the band just done
  logic [16:0] mix_gain_q;
  logic mix_pend;

  logic [EW-1:0] band_ix;
  assign band_ix = band[EW-1:0];

  // coefficient selection from the constant tables
  always_comb begin
    int unsigned t;
    t = (int'(band) < cvsb_pkg::TableLen) ? int'(band) : cvsb_pkg::TableLen - 1;
    f_coef = stage[0] ? cvsb_pkg::cut_second(t) : cvsb_pkg::cut_first(t);
    q_coef = stage[0] ? {2'b0, damp2} : {2'b0, damp1};
  end

  always_comb begin
    int unsigned t;
    t = (int'(band) < cvsb_pkg::TableLen) ? int'(band) : cvsb_pkg::TableLen - 1;
    prod = mula * $signed({1'b0, mulc});
    mix_g = cvsb_pkg::mix_level(t);
  end

  logic [AW-1:0] stage_addr;
  always_comb begin
    stage_addr = AW'(int'(stage) * BANDS + int'(band));
  end

  // multiply operand selection, one product per cycle
  always_comb begin
    mula = 33'(b);
    mulc = f_coef;
    unique case (phase)
      P_LO: begin mula = 33'(b); mulc = f_coef; end
      P_HI1: begin mula = 33'(b); mulc = q_coef; end
      P_BP: begin mula = 33'(hi); mulc = f_coef; end
      default: begin mula = 33'(b); mulc = f_coef; end
    endcase
    if (tail == 2'd1) begin mula = 33'(env_rd); mulc = {2'b0, env_decay}; end
    if (tail == 2'd2) begin mula = mag; mulc = 18'(17'h10000 - {1'b0, env_decay}); end
  end

  logic signed [63:0] ep;
  logic signed [34:0] env_part;
  logic signed [31:0] env_new;
  logic signed [63:0] mixp;

  always_comb begin
    mem_we = 1'b0;
    mem_addr = stage_addr;
    lp_wdata = lo;
    bp_wdata = b;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_addr = clr_cnt;
      lp_wdata = '0;
      bp_wdata = '0;
    end else if (state == S_RUN && tail == 2'd0 && phase == P_WR) begin
      mem_we = 1'b1;
    end
    env_addr = (state == S_CLEAR) ? clr_cnt[EW-1:0] : band_ix;
    env_we = (state == S_CLEAR && clr_cnt < AW'(BANDS)) ||
             (state == S_RUN && tail == 2'd3);
    env_wdata = (state == S_CLEAR) ? '0 : env_new;
  end

  always_comb begin
    stg_in = car_x;
    unique case (stage)
      2'd0: stg_in = car_x;
      2'd1: stg_in = car_bp2;
      2'd2: stg_in = mod_x;
      default: stg_in = mod_bp1;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      band <= '0;
      stage <= '0;
      phase <= '0;
      tail <= '0;
      mix_pend <= 1'b0;
    end else begin
      // mix term of the previous band lands in the cycle after its envelope
      if (mix_pend) begin
        acc <= acc + mixp;
        mix_pend <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(Entries - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            car_x <= 32'(carrier_sample) <<< 9;
            mod_x <= 32'(modulator_sample) <<< 9;
            acc <= '0;
            band <= '0;
            stage <= '0;
            phase <= P_READ;
            tail <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (tail == 2'd0) begin
            unique case (phase)
              P_READ: phase <= P_WAIT;
              P_WAIT: begin b <= bp_rd; lo <= lp_rd; phase <= P_LO; end
              P_LO: begin
                lo <= cvsb_pkg::sat32(36'(lo) + 36'(cvsb_pkg::rnd16(prod)));
                phase <= P_HI1;
              end
              P_HI1: begin
                tmp <= 36'(stg_in) - 36'(lo) - 36'(cvsb_pkg::rnd16(prod));
                phase <= P_HI2;
              end
              P_HI2: begin hi <= cvsb_pkg::sat32(tmp); phase <= P_BP; end
              P_BP: begin
                b <= cvsb_pkg::sat32(36'(b) + 36'(cvsb_pkg::rnd16(prod)));
                phase <= P_WR;
              end
              default: begin
                if (stage == 2'd0) car_bp2 <= b;
                if (stage == 2'd2) mod_bp1 <= b;
                if (stage == 2'd1) car_band <= b; // carrier stage-two bandpass kept
                if (stage == 2'd3) begin
                  mag <= b[31] ? -33'(b) : 33'(b);
                  tail <= 2'd1;
                end
                stage <= stage + 1'b1;
                phase <= P_READ;
              end
            endcase
          end else if (tail == 2'd1) begin
            env_part <= cvsb_pkg::rnd16(prod);
            tail <= 2'd2;
          end else if (tail == 2'd2) begin
            env_part <= env_part + cvsb_pkg::rnd16(prod);
            tail <= 2'd3;
          end else begin
            // envelope written this cycle; mix term from new envelope
            mix_term <= 40'(ep >>> 24);
            mix_gain_q <= mix_g;
            mix_pend <= 1'b1;
            tail <= 2'd0;
            if (band == BW'(BANDS - 1)) state <= S_OUT;
            else band <= band + 1'b1;
          end
        end
        default: begin
          if (!out_valid && !mix_pend) begin
            output_sample <= res;
            out_valid <= 1'b1;
          end else if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // car_band holds the carrier stage-two bandpass by the time the tail runs
  always_comb begin
    env_new = cvsb_pkg::sat32(36'(env_part));
    ep = 64'(env_new) * 64'(car_band);
    mixp = 64'(mix_term) * $signed({47'b0, mix_gain_q});
  end

  always_comb begin
    logic signed [63:0] r;
    r = acc[63] ? -((-acc) >>> 26) : (acc >>> 26);
    if (r > 64'sd32767) res = 16'sh7fff;
    else if (r < -64'sd32768) res = 16'sh8000;
    else res = r[15:0];
  end

  property p_stall_busy;
    @(posedge clk) disable iff (rst) (state == S_RUN) |-> in_stall;
  endproperty
  a_stall_busy: assert property (p_stall_busy) else $error("accept while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(output_sample)))
    else $error("result dropped");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid)
    else $error("output during clear");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the ten-band SVF channel vocoder unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_BANDS = 10;
  localparam int unsigned LATENCY   = NUM_BANDS * 31 + 2;
  localparam longint      CYCLE_LIMIT = 4_000_000;
  localparam int          PHASE_WORDS = 250;
  localparam int          NUM_PHASES  = 5;

  // Fixed cutoff and mix tables, Q1.16
  localparam int unsigned TUNE_ONE [NUM_BANDS] = '{1955, 2807, 4055, 6081, 9117,
                                                   13330, 19481, 27862, 39911, 58671};
  localparam int unsigned TUNE_TWO [NUM_BANDS] = '{2369, 3401, 4912, 7366, 11041,
                                                   16136, 23559, 33633, 47987, 69873};
  localparam int unsigned MIX_LEVEL[NUM_BANDS] = '{65536, 65536, 65536, 65536, 53971,
                                                   44756, 36700, 36700, 36700, 36700};

  typedef struct {
    logic signed [15:0] carrier;
    logic signed [15:0] modulator;
    bit                 known;
    logic signed [15:0] result;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] carrier_sample = '0;
  logic signed [15:0] modulator_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] output_sample;

  channel_vocoder_svf_bank_unit #(.BANDS(NUM_BANDS)) u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .carrier_sample, .modulator_sample,
    .out_valid, .out_stall, .output_sample
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the filter bank: state Q8.24, registers Q0.16
  longint             lp_mirror [4*NUM_BANDS];
  longint             bp_mirror [4*NUM_BANDS];
  longint             env_mirror[NUM_BANDS];
  int unsigned        decay_reg, damp1_reg, damp2_reg;
  logic signed [15:0] pending_samples[$];
  int                 mismatches = 0;
  int                 words_out = 0;
  int                 words_in = 0;
  int                 saturated_out = 0;
  longint             cycles = 0;
  bit                 quiet_mode = 1'b0;   // stretch with no idling on either side

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round half up after a Q.16 multiply; >>> on longint floors
  function automatic longint scale_q16(longint a, int unsigned c);
    return (a * longint'(c) + 64'sd32768) >>> 16;
  endfunction

  function automatic void svf_update(int k, longint x, int unsigned f, int unsigned q);
    longint b, lo, hi;
    b  = bp_mirror[k];
    lo = clamp32(lp_mirror[k] + scale_q16(b, f));
    hi = clamp32(x - lo - scale_q16(b, q));
    lp_mirror[k] = lo;
    bp_mirror[k] = clamp32(b + scale_q16(hi, f));
  endfunction

  function automatic void clear_mirror();
    foreach (lp_mirror[i]) begin
      lp_mirror[i] = 0;
      bp_mirror[i] = 0;
    end
    foreach (env_mirror[i]) env_mirror[i] = 0;
    decay_reg = 64667;
    damp1_reg = 9509;
    damp2_reg = 9593;
  endfunction

  function automatic logic signed [15:0] vocode_sample(logic signed [15:0] c,
                                                       logic signed [15:0] m);
    longint car, md, mag, acc, r;
    int unsigned gain_in;
    car = longint'(c) * 512;
    md  = longint'(m) * 512;
    gain_in = 65536 - decay_reg;
    acc = 0;
    for (int i = 0; i < NUM_BANDS; i++) begin
      svf_update(i, car, TUNE_ONE[i], damp1_reg);
      svf_update(NUM_BANDS + i, bp_mirror[i], TUNE_TWO[i], damp2_reg);
      svf_update(2*NUM_BANDS + i, md, TUNE_ONE[i], damp1_reg);
      svf_update(3*NUM_BANDS + i, bp_mirror[2*NUM_BANDS + i], TUNE_TWO[i], damp2_reg);
      mag = bp_mirror[3*NUM_BANDS + i];
      if (mag < 0) mag = -mag;
      env_mirror[i] = clamp32(scale_q16(env_mirror[i], decay_reg) + scale_q16(mag, gain_in));
    end
    for (int i = 0; i < NUM_BANDS; i++)
      acc += ((env_mirror[i] * bp_mirror[NUM_BANDS + i]) >>> 24) * longint'(MIX_LEVEL[i]);
    // truncate toward zero, then saturate
    r = (acc >= 0) ? (acc >>> 26) : -((-acc) >>> 26);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Receiver back-pressure, same shape
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               pending_samples.size());
      $display("channel_vocoder_svf_bank_unit verification failed");
      $finish;
    end
  end

  // Result checker: compare every accepted word against the oldest expectation
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst && out_valid && !out_stall) begin
      words_out++;
      if (output_sample == 16'sh7fff || output_sample == -16'sh8000) saturated_out++;
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %0d", output_sample);
      end else begin
        want = pending_samples.pop_front();
        if (output_sample !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: output_sample expected %0d got %0d",
                     words_out, want, output_sample);
        end
      end
    end
  end

  // Present one word, hold it until taken, then record its expectation
  task automatic send_word(logic signed [15:0] c, logic signed [15:0] m,
                           bit known, logic signed [15:0] typed);
    int g;
    logic signed [15:0] pred;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid         <= 1'b1;
    carrier_sample   <= c;
    modulator_sample <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = vocode_sample(c, m);
    pending_samples.push_back(known ? typed : pred);
    words_in++;
  endtask

  // Let the pipe drain completely before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      cvsb_pkg::RegEnvDecay:   decay_reg = val;
      cvsb_pkg::RegDampFirst:  damp1_reg = val;
      cvsb_pkg::RegDampSecond: damp2_reg = val;
      default: ;   // out-of-range index is dropped by the block
    endcase
  endtask

  stim_row_t directed[14] = '{
    '{16'sd0,      16'sd0,      1'b1, 16'sd0},   // zero state, zero in
    '{16'sd32767,  16'sd32767,  1'b0, 16'sd0},
    '{-16'sd32768, -16'sd32768, 1'b0, 16'sd0},
    '{16'sd32767,  -16'sd32768, 1'b0, 16'sd0},
    '{-16'sd32768, 16'sd32767,  1'b0, 16'sd0},
    '{16'sd32767,  16'sd32767,  1'b0, 16'sd0},
    '{-16'sd32768, -16'sd32768, 1'b0, 16'sd0},
    '{16'sd32767,  16'sd32767,  1'b0, 16'sd0},
    '{-16'sd32768, -16'sd32768, 1'b0, 16'sd0},
    '{16'sd1,      -16'sd1,     1'b0, 16'sd0},
    '{-16'sd1,     16'sd1,      1'b0, 16'sd0},
    '{16'sh5555,   16'shAAAA,   1'b0, 16'sd0},
    '{16'shAAAA,   16'sh5555,   1'b0, 16'sd0},
    '{16'sd0,      16'sd0,      1'b0, 16'sd0}
  };

  initial begin
    int mode, seg_len, period, amp, n, ph;
    logic signed [15:0] c, m;
    clear_mirror();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_word(directed[i].carrier, directed[i].modulator,
                directed[i].known, directed[i].result);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // registers change only with the pipe empty
      drain();
      case (ph)
        0: ;   // stay on reset defaults
        1: begin
          write_reg(cvsb_pkg::RegEnvDecay, 16'd0);
          write_reg(cvsb_pkg::RegDampFirst, 16'd0);
          write_reg(cvsb_pkg::RegDampSecond, 16'd0);
        end
        2: begin
          write_reg(cvsb_pkg::RegEnvDecay, 16'hffff);
          write_reg(cvsb_pkg::RegDampFirst, 16'hffff);
          write_reg(cvsb_pkg::RegDampSecond, 16'hffff);
          write_reg(2'd3, 16'h1234);   // no such register
        end
        default: begin
          write_reg(cvsb_pkg::RegEnvDecay, 16'($urandom_range(60000, 65535)));
          write_reg(cvsb_pkg::RegDampFirst, 16'($urandom));
          write_reg(cvsb_pkg::RegDampSecond, 16'($urandom_range(2000, 30000)));
        end
      endcase
      n = 0;
      while (n < PHASE_WORDS) begin
        mode       = $urandom_range(0, 3);
        seg_len    = $urandom_range(15, 60);
        period     = $urandom_range(2, 48);
        amp        = $urandom_range(0, 32767);
        quiet_mode = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < seg_len && n < PHASE_WORDS; k++, n++) begin
          case (mode)
            0: begin   // full-range noise
              c = 16'($urandom);
              m = 16'($urandom);
            end
            1: begin   // square waves, modulator at full scale
              c = ((k / period) % 2) ? 16'(amp) : 16'(-amp - 1);
              m = ((k / (period + 1)) % 2) ? 16'sd32767 : -16'sd32768;
            end
            2: begin   // quiet noise
              c = 16'($signed($urandom_range(0, 511)) - 256);
              m = 16'($signed($urandom_range(0, 511)) - 256);
            end
            default: begin   // noisy carrier under a square modulator
              c = 16'($urandom);
              m = ((k / period) % 2) ? 16'(amp) : 16'(-amp);
            end
          endcase
          send_word(c, m, 1'b0, 16'sd0);
        end
      end
    end
    quiet_mode = 1'b0;

    drain();
    $display("%0d words in, %0d out, %0d saturated, %0d config phases", words_in,
             words_out, saturated_out, NUM_PHASES);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("channel_vocoder_svf_bank_unit verification clean");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, pending_samples.size());
      $display("channel_vocoder_svf_bank_unit verification failed");
    end
    $finish;
  end

endmodule
